// File: sv/idw_pkg.sv
// Package with constants, codes, transaction types and states of the displacement morph core.
`default_nettype none

package idw_pkg;

  localparam int MAX_POINTS      = 64;
  localparam int PTR_W           = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int CNT_W           = $clog2(MAX_POINTS + 1);
  localparam int EPS_Q           = 655;
  localparam int SEARCH_STEPS    = 11;
  localparam int IT_W            = $clog2(SEARCH_STEPS + 1);
  localparam int WEIGHT_BITS     = 20;
  localparam int W_W             = WEIGHT_BITS + 1;
  localparam int PROD_W          = W_W + 1 + 32;
  localparam int GRAD_LIMIT_BITS = 21;
  localparam int SH_W            = 4;
  localparam int DCNT_W          = 7;

  localparam logic [1:0] REQ_CLEAR  = 2'd0;
  localparam logic [1:0] REQ_INSERT = 2'd1;
  localparam logic [1:0] REQ_FWD    = 2'd2;
  localparam logic [1:0] REQ_BWD    = 2'd3;

  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_FULL  = 2'd1;
  localparam logic [1:0] STAT_EMPTY = 2'd2;

  typedef struct packed {
    logic [1:0]         req_type;
    logic signed [31:0] src_x;
    logic signed [31:0] src_y;
    logic signed [31:0] dst_x;
    logic signed [31:0] dst_y;
    logic signed [31:0] guess_x;
    logic signed [31:0] guess_y;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] out_x;
    logic signed [31:0] out_y;
    logic [1:0]         status;
  } out_item_t;

  typedef struct packed {
    logic signed [31:0] src_x;
    logic signed [31:0] src_y;
    logic signed [31:0] disp_x;
    logic signed [31:0] disp_y;
  } point_t;

  typedef enum logic [1:0] {PH_BASE, PH_XEPS, PH_YEPS} phase_t;

  typedef enum logic [4:0] {
    S_IDLE, S_B_EVAL,
    S_F_RD1, S_F_MUL1, S_F_CMP1,
    S_F_RD2, S_F_MUL2, S_F_W, S_F_RDIV, S_F_ACC, S_F_ADD,
    S_F_XSET, S_F_XDIV, S_F_YDIV, S_F_RES,
    S_M_MUL, S_M_SUM, S_M_SQRT,
    S_B_GRAD, S_B_SHF, S_B_DEN, S_B_DSUM, S_B_NUM, S_B_NUM2, S_B_SDIV
  } state_t;

endpackage

`default_nettype wire

// File: sv/idw_displacement_morph_core.sv
// Top level of the inverse-distance-weighted displacement morph core.
//
// The core keeps its control points in one table with a registered read and handles one
// transaction at a time; busy is high while it works. Clear and insert are handled in the
// idle state and leave busy low. A forward map over N points makes a nearest-distance pass
// and then a weighting pass (a 20-step serial divider for each point farther than the
// nearest), then two 64-step output divisions; an exact hit ends the first pass early. A
// backward map takes up to eleven search steps, each of up to three forward maps, each
// followed by a 32-step square root, and two divisions for the gradient step. The result
// appears for exactly one cycle with out_valid and the receiver cannot stall it.
`default_nettype none

module idw_displacement_morph_core (
  input  wire                   clk,
  input  wire                   rst_n,
  input  wire                   start,
  output logic                  busy,
  input  idw_pkg::in_item_t     in_req,
  output logic                  out_valid,
  output idw_pkg::out_item_t    out_res
);

  function automatic logic signed [65:0] sx66(input logic [31:0] a);
    return {{34{a[31]}}, a};
  endfunction

  function automatic logic [31:0] sat32(input logic signed [65:0] v);
    if (v > 66'sd2147483647) begin
      return 32'h7FFF_FFFF;
    end else if (v < -66'sd2147483648) begin
      return 32'h8000_0000;
    end else begin
      return v[31:0];
    end
  endfunction

  idw_pkg::point_t mem [idw_pkg::MAX_POINTS];
  idw_pkg::point_t mem_q_r;
  logic                       rd_en, wr_en;
  logic [idw_pkg::PTR_W-1:0]  rd_addr;
  idw_pkg::point_t            wr_data;

  idw_pkg::state_t state_r, state_nxt;
  idw_pkg::phase_t ph_r, ph_nxt;
  logic [1:0]                req_r, req_nxt;
  logic [idw_pkg::CNT_W-1:0] count_r, count_nxt, idx_r, idx_nxt;
  logic [idw_pkg::IT_W-1:0]  it_r, it_nxt;
  logic                      co_r, co_nxt;
  logic                      out_valid_r, out_valid_nxt;
  idw_pkg::out_item_t        out_res_r, out_res_nxt;

  logic [31:0] p_x_r, p_x_nxt, p_y_r, p_y_nxt, t_x_r, t_x_nxt, t_y_r, t_y_nxt;
  logic [31:0] x_r, x_nxt, y_r, y_nxt, fx_r, fx_nxt, fy_r, fy_nxt;
  logic [31:0] f_r, f_nxt, fa_r, fa_nxt;
  logic [63:0] dmin_r, dmin_nxt, sumw_r, sumw_nxt;
  logic signed [63:0] sumx_r, sumx_nxt, sumy_r, sumy_nxt;
  logic [idw_pkg::W_W-1:0] w_r, w_nxt;
  logic signed [idw_pkg::PROD_W-1:0] prx_r, prx_nxt, pry_r, pry_nxt;
  logic [63:0] sqa_r, sqa_nxt, sqb_r, sqb_nxt;
  logic signed [32:0] ga_r, ga_nxt, gb_r, gb_nxt;
  logic [31:0] mxs_r, mxs_nxt;
  logic [idw_pkg::SH_W-1:0] s_r, s_nxt;
  logic [idw_pkg::GRAD_LIMIT_BITS-1:0] ma_r, ma_nxt, mb_r, mb_nxt;
  logic [63:0] den_r, den_nxt, num1_r, num1_nxt;
  logic [63:0] dv_rem_r, dv_rem_nxt, dv_num_r, dv_num_nxt, dv_q_r, dv_q_nxt;
  logic [63:0] dv_den_r, dv_den_nxt;
  logic [idw_pkg::DCNT_W-1:0] dv_cnt_r, dv_cnt_nxt;
  logic [63:0] sn_r, sn_nxt, sr_r, sr_nxt, sb_r, sb_nxt;

  logic [31:0] da_x, da_y, db_x, db_y, mag_x, mag_y, ma_full, mb_full;
  logic signed [32:0] dif_x, dif_y;
  logic [64:0] d2_sum, dv_sh;
  logic [63:0] d2, dv_rem_s, dv_q_s, sq_t, mag_sx, mag_sy;
  logic dv_ge, last_pt;
  logic signed [65:0] step_v;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[count_r[idw_pkg::PTR_W-1:0]] <= wr_data;
    end
    if (rd_en) begin
      mem_q_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= idw_pkg::S_IDLE;
      ph_r        <= idw_pkg::PH_BASE;
      req_r       <= idw_pkg::REQ_CLEAR;
      count_r     <= '0;
      idx_r       <= '0;
      it_r        <= '0;
      co_r        <= 1'b0;
      out_valid_r <= 1'b0;
      dv_cnt_r    <= '0;
      s_r         <= '0;
    end else begin
      state_r     <= state_nxt;
      ph_r        <= ph_nxt;
      req_r       <= req_nxt;
      count_r     <= count_nxt;
      idx_r       <= idx_nxt;
      it_r        <= it_nxt;
      co_r        <= co_nxt;
      out_valid_r <= out_valid_nxt;
      dv_cnt_r    <= dv_cnt_nxt;
      s_r         <= s_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_res_r <= out_res_nxt;
    p_x_r <= p_x_nxt;  p_y_r <= p_y_nxt;  t_x_r <= t_x_nxt;  t_y_r <= t_y_nxt;
    x_r <= x_nxt;      y_r <= y_nxt;      fx_r <= fx_nxt;    fy_r <= fy_nxt;
    f_r <= f_nxt;      fa_r <= fa_nxt;    dmin_r <= dmin_nxt; sumw_r <= sumw_nxt;
    sumx_r <= sumx_nxt; sumy_r <= sumy_nxt; w_r <= w_nxt;
    prx_r <= prx_nxt;  pry_r <= pry_nxt;  sqa_r <= sqa_nxt;  sqb_r <= sqb_nxt;
    ga_r <= ga_nxt;    gb_r <= gb_nxt;    mxs_r <= mxs_nxt;
    ma_r <= ma_nxt;    mb_r <= mb_nxt;    den_r <= den_nxt;  num1_r <= num1_nxt;
    dv_rem_r <= dv_rem_nxt; dv_num_r <= dv_num_nxt; dv_q_r <= dv_q_nxt;
    dv_den_r <= dv_den_nxt;
    sn_r <= sn_nxt;    sr_r <= sr_nxt;    sb_r <= sb_nxt;
  end

  always_comb begin
    if (state_r == idw_pkg::S_M_MUL) begin
      da_x = t_x_r;  da_y = t_y_r;  db_x = fx_r;  db_y = fy_r;
    end else begin
      da_x = mem_q_r.src_x;  da_y = mem_q_r.src_y;  db_x = p_x_r;  db_y = p_y_r;
    end
    dif_x = $signed({da_x[31], da_x}) - $signed({db_x[31], db_x});
    dif_y = $signed({da_y[31], da_y}) - $signed({db_y[31], db_y});
    mag_x = dif_x[32] ? 32'(-dif_x) : dif_x[31:0];
    mag_y = dif_y[32] ? 32'(-dif_y) : dif_y[31:0];
    d2_sum = {1'b0, sqa_r} + {1'b0, sqb_r};
    d2 = d2_sum[64] ? '1 : d2_sum[63:0];
    dv_sh = {dv_rem_r, dv_num_r[63]};
    dv_ge = dv_sh >= {1'b0, dv_den_r};
    dv_rem_s = dv_ge ? 64'(dv_sh - {1'b0, dv_den_r}) : dv_sh[63:0];
    dv_q_s = {dv_q_r[62:0], dv_ge};
    sq_t = sr_r + sb_r;
    mag_sx = sumx_r[63] ? 64'(-sumx_r) : 64'(sumx_r);
    mag_sy = sumy_r[63] ? 64'(-sumy_r) : 64'(sumy_r);
    ma_full = ga_r[32] ? 32'(-ga_r) : ga_r[31:0];
    mb_full = gb_r[32] ? 32'(-gb_r) : gb_r[31:0];
    last_pt = idw_pkg::CNT_W'(idx_r + 1'b1) == count_r;
    if (co_r) begin
      step_v = gb_r[32] ? sx66(y_r) + $signed({2'b00, dv_q_s})
                        : sx66(y_r) - $signed({2'b00, dv_q_s});
    end else begin
      step_v = ga_r[32] ? sx66(x_r) + $signed({2'b00, dv_q_s})
                        : sx66(x_r) - $signed({2'b00, dv_q_s});
    end
  end

  always_comb begin
    state_nxt = state_r;  ph_nxt = ph_r;  req_nxt = req_r;  count_nxt = count_r;
    idx_nxt = idx_r;  it_nxt = it_r;  co_nxt = co_r;
    out_valid_nxt = 1'b0;  out_res_nxt = out_res_r;
    p_x_nxt = p_x_r;  p_y_nxt = p_y_r;  t_x_nxt = t_x_r;  t_y_nxt = t_y_r;
    x_nxt = x_r;  y_nxt = y_r;  fx_nxt = fx_r;  fy_nxt = fy_r;  f_nxt = f_r;  fa_nxt = fa_r;
    dmin_nxt = dmin_r;  sumw_nxt = sumw_r;  sumx_nxt = sumx_r;  sumy_nxt = sumy_r;
    w_nxt = w_r;  prx_nxt = prx_r;  pry_nxt = pry_r;  sqa_nxt = sqa_r;  sqb_nxt = sqb_r;
    ga_nxt = ga_r;  gb_nxt = gb_r;  mxs_nxt = mxs_r;  s_nxt = s_r;
    ma_nxt = ma_r;  mb_nxt = mb_r;  den_nxt = den_r;  num1_nxt = num1_r;
    dv_rem_nxt = dv_rem_r;  dv_num_nxt = dv_num_r;  dv_q_nxt = dv_q_r;
    dv_den_nxt = dv_den_r;  dv_cnt_nxt = dv_cnt_r;
    sn_nxt = sn_r;  sr_nxt = sr_r;  sb_nxt = sb_r;
    rd_en = 1'b0;  rd_addr = idx_r[idw_pkg::PTR_W-1:0];
    wr_en = 1'b0;
    wr_data.src_x  = in_req.src_x;
    wr_data.src_y  = in_req.src_y;
    wr_data.disp_x = sat32(sx66(in_req.dst_x) - sx66(in_req.src_x));
    wr_data.disp_y = sat32(sx66(in_req.dst_y) - sx66(in_req.src_y));

    case (state_r)
      idw_pkg::S_IDLE: begin
        if (start) begin
          req_nxt = in_req.req_type;
          out_res_nxt.out_x  = '0;
          out_res_nxt.out_y  = '0;
          out_res_nxt.status = idw_pkg::STAT_OK;
          case (in_req.req_type)
            idw_pkg::REQ_CLEAR: begin
              count_nxt = '0;
              out_valid_nxt = 1'b1;
            end
            idw_pkg::REQ_INSERT: begin
              out_valid_nxt = 1'b1;
              if (count_r >= idw_pkg::CNT_W'(idw_pkg::MAX_POINTS)) begin
                out_res_nxt.status = idw_pkg::STAT_FULL;
              end else begin
                wr_en = 1'b1;
                count_nxt = count_r + 1'b1;
              end
            end
            idw_pkg::REQ_FWD: begin
              if (count_r == '0) begin
                out_valid_nxt = 1'b1;
                out_res_nxt.out_x  = in_req.src_x;
                out_res_nxt.out_y  = in_req.src_y;
                out_res_nxt.status = idw_pkg::STAT_EMPTY;
              end else begin
                p_x_nxt = in_req.src_x;
                p_y_nxt = in_req.src_y;
                idx_nxt = '0;
                dmin_nxt = '1;
                state_nxt = idw_pkg::S_F_RD1;
              end
            end
            default: begin
              if (count_r == '0) begin
                out_valid_nxt = 1'b1;
                out_res_nxt.out_x  = in_req.guess_x;
                out_res_nxt.out_y  = in_req.guess_y;
                out_res_nxt.status = idw_pkg::STAT_EMPTY;
              end else begin
                x_nxt = in_req.guess_x;
                y_nxt = in_req.guess_y;
                t_x_nxt = in_req.dst_x;
                t_y_nxt = in_req.dst_y;
                it_nxt = '0;
                ph_nxt = idw_pkg::PH_BASE;
                state_nxt = idw_pkg::S_B_EVAL;
              end
            end
          endcase
        end
      end
      idw_pkg::S_B_EVAL: begin
        p_x_nxt = x_r;
        p_y_nxt = y_r;
        if (ph_r == idw_pkg::PH_XEPS) begin
          p_x_nxt = sat32(sx66(x_r) + 66'(idw_pkg::EPS_Q));
        end else if (ph_r == idw_pkg::PH_YEPS) begin
          p_y_nxt = sat32(sx66(y_r) + 66'(idw_pkg::EPS_Q));
        end
        idx_nxt = '0;
        dmin_nxt = '1;
        state_nxt = idw_pkg::S_F_RD1;
      end
      idw_pkg::S_F_RD1: begin
        rd_en = 1'b1;
        state_nxt = idw_pkg::S_F_MUL1;
      end
      idw_pkg::S_F_MUL1: begin
        sqa_nxt = 64'(mag_x) * 64'(mag_x);
        sqb_nxt = 64'(mag_y) * 64'(mag_y);
        state_nxt = idw_pkg::S_F_CMP1;
      end
      idw_pkg::S_F_CMP1: begin
        if (d2 == '0) begin
          fx_nxt = sat32(sx66(mem_q_r.src_x) + sx66(mem_q_r.disp_x));
          fy_nxt = sat32(sx66(mem_q_r.src_y) + sx66(mem_q_r.disp_y));
          state_nxt = idw_pkg::S_F_RES;
        end else begin
          if (d2 < dmin_r) begin
            dmin_nxt = d2;
          end
          if (last_pt) begin
            idx_nxt = '0;
            sumw_nxt = '0;
            sumx_nxt = '0;
            sumy_nxt = '0;
            state_nxt = idw_pkg::S_F_RD2;
          end else begin
            idx_nxt = idx_r + 1'b1;
            state_nxt = idw_pkg::S_F_RD1;
          end
        end
      end
      idw_pkg::S_F_RD2: begin
        rd_en = 1'b1;
        state_nxt = idw_pkg::S_F_MUL2;
      end
      idw_pkg::S_F_MUL2: begin
        sqa_nxt = 64'(mag_x) * 64'(mag_x);
        sqb_nxt = 64'(mag_y) * 64'(mag_y);
        state_nxt = idw_pkg::S_F_W;
      end
      idw_pkg::S_F_W: begin
        if (dmin_r >= d2) begin
          w_nxt = idw_pkg::W_W'(1) << idw_pkg::WEIGHT_BITS;
          state_nxt = idw_pkg::S_F_ACC;
        end else begin
          dv_rem_nxt = dmin_r;
          dv_num_nxt = '0;
          dv_q_nxt = '0;
          dv_den_nxt = d2;
          dv_cnt_nxt = idw_pkg::DCNT_W'(idw_pkg::WEIGHT_BITS);
          state_nxt = idw_pkg::S_F_RDIV;
        end
      end
      idw_pkg::S_F_RDIV: begin
        dv_rem_nxt = dv_rem_s;
        dv_num_nxt = {dv_num_r[62:0], 1'b0};
        dv_q_nxt = dv_q_s;
        dv_cnt_nxt = dv_cnt_r - 1'b1;
        if (dv_cnt_r == idw_pkg::DCNT_W'(1)) begin
          w_nxt = dv_q_s[idw_pkg::W_W-1:0];
          state_nxt = idw_pkg::S_F_ACC;
        end
      end
      idw_pkg::S_F_ACC: begin
        prx_nxt = $signed({1'b0, w_r}) * mem_q_r.disp_x;
        pry_nxt = $signed({1'b0, w_r}) * mem_q_r.disp_y;
        state_nxt = idw_pkg::S_F_ADD;
      end
      idw_pkg::S_F_ADD: begin
        sumw_nxt = sumw_r + 64'(w_r);
        sumx_nxt = sumx_r + 64'(prx_r);
        sumy_nxt = sumy_r + 64'(pry_r);
        if (last_pt) begin
          state_nxt = idw_pkg::S_F_XSET;
        end else begin
          idx_nxt = idx_r + 1'b1;
          state_nxt = idw_pkg::S_F_RD2;
        end
      end
      idw_pkg::S_F_XSET: begin
        dv_rem_nxt = '0;
        dv_num_nxt = mag_sx + (sumw_r >> 1);
        dv_q_nxt = '0;
        dv_den_nxt = sumw_r;
        dv_cnt_nxt = idw_pkg::DCNT_W'(64);
        state_nxt = idw_pkg::S_F_XDIV;
      end
      idw_pkg::S_F_XDIV: begin
        dv_rem_nxt = dv_rem_s;
        dv_num_nxt = {dv_num_r[62:0], 1'b0};
        dv_q_nxt = dv_q_s;
        dv_cnt_nxt = dv_cnt_r - 1'b1;
        if (dv_cnt_r == idw_pkg::DCNT_W'(1)) begin
          fx_nxt = sumx_r[63] ? sat32(sx66(p_x_r) - $signed({2'b00, dv_q_s}))
                              : sat32(sx66(p_x_r) + $signed({2'b00, dv_q_s}));
          dv_rem_nxt = '0;
          dv_num_nxt = mag_sy + (sumw_r >> 1);
          dv_q_nxt = '0;
          dv_cnt_nxt = idw_pkg::DCNT_W'(64);
          state_nxt = idw_pkg::S_F_YDIV;
        end
      end
      idw_pkg::S_F_YDIV: begin
        dv_rem_nxt = dv_rem_s;
        dv_num_nxt = {dv_num_r[62:0], 1'b0};
        dv_q_nxt = dv_q_s;
        dv_cnt_nxt = dv_cnt_r - 1'b1;
        if (dv_cnt_r == idw_pkg::DCNT_W'(1)) begin
          fy_nxt = sumy_r[63] ? sat32(sx66(p_y_r) - $signed({2'b00, dv_q_s}))
                              : sat32(sx66(p_y_r) + $signed({2'b00, dv_q_s}));
          state_nxt = idw_pkg::S_F_RES;
        end
      end
      idw_pkg::S_F_RES: begin
        if (req_r == idw_pkg::REQ_FWD) begin
          out_valid_nxt = 1'b1;
          out_res_nxt.out_x  = fx_r;
          out_res_nxt.out_y  = fy_r;
          out_res_nxt.status = idw_pkg::STAT_OK;
          state_nxt = idw_pkg::S_IDLE;
        end else begin
          state_nxt = idw_pkg::S_M_MUL;
        end
      end
      idw_pkg::S_M_MUL: begin
        sqa_nxt = 64'(mag_x) * 64'(mag_x);
        sqb_nxt = 64'(mag_y) * 64'(mag_y);
        state_nxt = idw_pkg::S_M_SUM;
      end
      idw_pkg::S_M_SUM: begin
        sn_nxt = d2;
        sr_nxt = '0;
        sb_nxt = 64'd1 << 62;
        state_nxt = idw_pkg::S_M_SQRT;
      end
      idw_pkg::S_M_SQRT: begin
        if (sb_r != '0) begin
          if (sn_r >= sq_t) begin
            sn_nxt = sn_r - sq_t;
            sr_nxt = (sr_r >> 1) + sb_r;
          end else begin
            sr_nxt = sr_r >> 1;
          end
          sb_nxt = sb_r >> 2;
        end else begin
          case (ph_r)
            idw_pkg::PH_BASE: begin
              f_nxt = sr_r[31:0];
              if (sr_r[31:0] < 32'(idw_pkg::EPS_Q)) begin
                out_valid_nxt = 1'b1;
                out_res_nxt.out_x  = x_r;
                out_res_nxt.out_y  = y_r;
                out_res_nxt.status = idw_pkg::STAT_OK;
                state_nxt = idw_pkg::S_IDLE;
              end else begin
                ph_nxt = idw_pkg::PH_XEPS;
                state_nxt = idw_pkg::S_B_EVAL;
              end
            end
            idw_pkg::PH_XEPS: begin
              fa_nxt = sr_r[31:0];
              ph_nxt = idw_pkg::PH_YEPS;
              state_nxt = idw_pkg::S_B_EVAL;
            end
            default: begin
              ga_nxt = $signed({1'b0, fa_r}) - $signed({1'b0, f_r});
              gb_nxt = $signed({1'b0, sr_r[31:0]}) - $signed({1'b0, f_r});
              state_nxt = idw_pkg::S_B_GRAD;
            end
          endcase
        end
      end
      idw_pkg::S_B_GRAD: begin
        if (ga_r == '0 && gb_r == '0) begin
          out_valid_nxt = 1'b1;
          out_res_nxt.out_x  = x_r;
          out_res_nxt.out_y  = y_r;
          out_res_nxt.status = idw_pkg::STAT_OK;
          state_nxt = idw_pkg::S_IDLE;
        end else begin
          mxs_nxt = (ma_full > mb_full) ? ma_full : mb_full;
          s_nxt = '0;
          state_nxt = idw_pkg::S_B_SHF;
        end
      end
      idw_pkg::S_B_SHF: begin
        if (mxs_r[31:idw_pkg::GRAD_LIMIT_BITS] != '0) begin
          mxs_nxt = mxs_r >> 1;
          s_nxt = s_r + 1'b1;
        end else begin
          ma_nxt = idw_pkg::GRAD_LIMIT_BITS'(ma_full >> s_r);
          mb_nxt = idw_pkg::GRAD_LIMIT_BITS'(mb_full >> s_r);
          state_nxt = idw_pkg::S_B_DEN;
        end
      end
      idw_pkg::S_B_DEN: begin
        sqa_nxt = 64'(ma_r) * 64'(ma_r);
        sqb_nxt = 64'(mb_r) * 64'(mb_r);
        state_nxt = idw_pkg::S_B_DSUM;
      end
      idw_pkg::S_B_DSUM: begin
        den_nxt = (sqa_r + sqb_r) << s_r;
        co_nxt = 1'b0;
        state_nxt = idw_pkg::S_B_NUM;
      end
      idw_pkg::S_B_NUM: begin
        num1_nxt = 64'(co_r ? mb_r : ma_r) * 64'(f_r);
        state_nxt = idw_pkg::S_B_NUM2;
      end
      idw_pkg::S_B_NUM2: begin
        dv_rem_nxt = '0;
        dv_num_nxt = num1_r * 64'(idw_pkg::EPS_Q) + (den_r >> 1);
        dv_q_nxt = '0;
        dv_den_nxt = den_r;
        dv_cnt_nxt = idw_pkg::DCNT_W'(64);
        state_nxt = idw_pkg::S_B_SDIV;
      end
      idw_pkg::S_B_SDIV: begin
        dv_rem_nxt = dv_rem_s;
        dv_num_nxt = {dv_num_r[62:0], 1'b0};
        dv_q_nxt = dv_q_s;
        dv_cnt_nxt = dv_cnt_r - 1'b1;
        if (dv_cnt_r == idw_pkg::DCNT_W'(1)) begin
          if (!co_r) begin
            x_nxt = sat32(step_v);
            co_nxt = 1'b1;
            state_nxt = idw_pkg::S_B_NUM;
          end else begin
            y_nxt = sat32(step_v);
            it_nxt = it_r + 1'b1;
            if (it_r == idw_pkg::IT_W'(idw_pkg::SEARCH_STEPS - 1)) begin
              out_valid_nxt = 1'b1;
              out_res_nxt.out_x  = x_r;
              out_res_nxt.out_y  = sat32(step_v);
              out_res_nxt.status = idw_pkg::STAT_OK;
              state_nxt = idw_pkg::S_IDLE;
            end else begin
              ph_nxt = idw_pkg::PH_BASE;
              state_nxt = idw_pkg::S_B_EVAL;
            end
          end
        end
      end
      default: begin
        state_nxt = idw_pkg::S_IDLE;
      end
    endcase
  end

  assign busy      = state_r != idw_pkg::S_IDLE;
  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

endmodule

`default_nettype wire

// File: verif/tb_idw_displacement_morph_core.sv
// Self-checking testbench for the displacement morph core: random and directed table/map traffic.
`timescale 1ns / 1ps

module tb_idw_displacement_morph_core;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  idw_pkg::in_item_t in_req = '0;
  logic out_valid;
  idw_pkg::out_item_t out_res;

  idw_displacement_morph_core dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_req(in_req), .out_valid(out_valid), .out_res(out_res)
  );

  always #4 clk = ~clk;

  logic signed [31:0] tbl_sx [idw_pkg::MAX_POINTS];
  logic signed [31:0] tbl_sy [idw_pkg::MAX_POINTS];
  logic signed [31:0] tbl_dx [idw_pkg::MAX_POINTS];
  logic signed [31:0] tbl_dy [idw_pkg::MAX_POINTS];
  int unsigned tbl_count = 0;

  idw_pkg::in_item_t pending_reqs[$];
  idw_pkg::out_item_t expected_results[$];
  int errors = 0;
  int n_accepted = 0;
  int n_results = 0;
  int gap_left = 0;
  bit hold_until_drained = 1'b0;
  bit accepted_now = 1'b0;

  function automatic void queue_req(idw_pkg::in_item_t r);
    pending_reqs.insert(pending_reqs.size(), r);
  endfunction

  function automatic logic signed [31:0] sat32(logic signed [65:0] v);
    if (v > 66'sd2147483647) return 32'sh7fffffff;
    if (v < -66'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  function automatic logic [63:0] mag64(logic signed [65:0] v);
    logic signed [65:0] a;
    a = (v < 0) ? -v : v;
    return a[63:0];
  endfunction

  function automatic logic [63:0] sq_dist(logic signed [31:0] ax, logic signed [31:0] ay,
                                          logic signed [31:0] bx, logic signed [31:0] by);
    logic [63:0] mx, my;
    logic [64:0] s;
    mx = mag64(66'(ax) - 66'(bx));
    my = mag64(66'(ay) - 66'(by));
    s = 65'(mx * mx) + 65'(my * my);
    return s[64] ? 64'hffff_ffff_ffff_ffff : s[63:0];
  endfunction

  function automatic logic [63:0] int_sqrt(logic [63:0] n);
    logic [63:0] r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n = n - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic logic [63:0] weight_q20(logic [63:0] a, logic [63:0] b);
    logic [63:0] q, r;
    logic cy;
    if (a >= b) return 64'd1 << idw_pkg::WEIGHT_BITS;
    q = 0;
    r = a;
    for (int i = 0; i < idw_pkg::WEIGHT_BITS; i++) begin
      cy = r[63];
      r = r << 1;
      q = q << 1;
      if (cy || r >= b) begin
        r = r - b;
        q[0] = 1'b1;
      end
    end
    return q;
  endfunction

  function automatic void warp_point(input logic signed [31:0] px,
                                     input logic signed [31:0] py,
                                     output logic signed [31:0] ox,
                                     output logic signed [31:0] oy);
    logic [63:0] dmin, sumw, d, w, q;
    logic signed [95:0] sumx, sumy;
    dmin = '1;
    sumw = 0;
    sumx = 0;
    sumy = 0;
    for (int i = 0; i < tbl_count; i++) begin
      d = sq_dist(tbl_sx[i], tbl_sy[i], px, py);
      if (d == 0) begin
        ox = sat32(66'(tbl_sx[i]) + 66'(tbl_dx[i]));
        oy = sat32(66'(tbl_sy[i]) + 66'(tbl_dy[i]));
        return;
      end
      if (d < dmin) dmin = d;
    end
    for (int i = 0; i < tbl_count; i++) begin
      w = weight_q20(dmin, sq_dist(tbl_sx[i], tbl_sy[i], px, py));
      sumw += w;
      sumx += $signed({32'd0, w}) * tbl_dx[i];
      sumy += $signed({32'd0, w}) * tbl_dy[i];
    end
    q = ((sumx < 0 ? -sumx : sumx) + sumw / 2) / sumw;
    ox = sat32(66'(px) + (sumx < 0 ? -$signed({2'b0, q}) : $signed({2'b0, q})));
    q = ((sumy < 0 ? -sumy : sumy) + sumw / 2) / sumw;
    oy = sat32(66'(py) + (sumy < 0 ? -$signed({2'b0, q}) : $signed({2'b0, q})));
  endfunction

  function automatic logic [63:0] miss_len(logic signed [31:0] x, logic signed [31:0] y,
                                           logic signed [31:0] tx, logic signed [31:0] ty);
    logic signed [31:0] fx, fy;
    warp_point(x, y, fx, fy);
    return int_sqrt(sq_dist(tx, ty, fx, fy));
  endfunction

  function automatic logic signed [31:0] step_coord(logic signed [31:0] x,
      logic signed [65:0] g, logic [63:0] gm, logic [63:0] f, logic [63:0] den);
    logic [127:0] st;
    st = (128'(gm) * f * idw_pkg::EPS_Q + den / 2) / den;
    return sat32(66'(x) - (g < 0 ? -$signed({2'b0, st[63:0]}) : $signed({2'b0, st[63:0]})));
  endfunction

  task automatic search_inverse(input logic signed [31:0] tx, input logic signed [31:0] ty,
                                inout logic signed [31:0] x, inout logic signed [31:0] y);
    logic [63:0] f, fa, fb, ma, mb, mx, den;
    logic signed [65:0] ga, gb;
    int s;
    for (int it = 0; it < idw_pkg::SEARCH_STEPS; it++) begin
      f = miss_len(x, y, tx, ty);
      if (f < idw_pkg::EPS_Q) break;
      fa = miss_len(sat32(66'(x) + idw_pkg::EPS_Q), y, tx, ty);
      fb = miss_len(x, sat32(66'(y) + idw_pkg::EPS_Q), tx, ty);
      ga = $signed({2'b0, fa}) - $signed({2'b0, f});
      gb = $signed({2'b0, fb}) - $signed({2'b0, f});
      if (ga == 0 && gb == 0) break;
      ma = mag64(ga);
      mb = mag64(gb);
      mx = ma > mb ? ma : mb;
      s = 0;
      while ((mx >> s) >= (64'd1 << idw_pkg::GRAD_LIMIT_BITS)) s++;
      ma = ma >> s;
      mb = mb >> s;
      den = (ma * ma + mb * mb) << s;
      x = step_coord(x, ga, ma, f, den);
      y = step_coord(y, gb, mb, f, den);
    end
  endtask

  task automatic predict_result(input idw_pkg::in_item_t r);
    idw_pkg::out_item_t e;
    logic signed [31:0] ox, oy;
    e = '0;
    case (r.req_type)
      idw_pkg::REQ_CLEAR: tbl_count = 0;
      idw_pkg::REQ_INSERT: begin
        if (tbl_count >= idw_pkg::MAX_POINTS) begin
          e.status = idw_pkg::STAT_FULL;
        end else begin
          tbl_sx[tbl_count] = r.src_x;
          tbl_sy[tbl_count] = r.src_y;
          tbl_dx[tbl_count] = sat32(66'(r.dst_x) - 66'(r.src_x));
          tbl_dy[tbl_count] = sat32(66'(r.dst_y) - 66'(r.src_y));
          tbl_count++;
        end
      end
      idw_pkg::REQ_FWD: begin
        if (tbl_count == 0) begin
          e.out_x = r.src_x;
          e.out_y = r.src_y;
          e.status = idw_pkg::STAT_EMPTY;
        end else begin
          warp_point(r.src_x, r.src_y, ox, oy);
          e.out_x = ox;
          e.out_y = oy;
        end
      end
      default: begin
        ox = r.guess_x;
        oy = r.guess_y;
        if (tbl_count == 0) e.status = idw_pkg::STAT_EMPTY;
        else search_inverse(r.dst_x, r.dst_y, ox, oy);
        e.out_x = ox;
        e.out_y = oy;
      end
    endcase
    expected_results.insert(expected_results.size(), e);
  endtask

  function automatic logic signed [31:0] rand_coord();
    case ($urandom_range(0, 9))
      0: return 32'sh7fffffff - $urandom_range(0, 3);
      1: return 32'sh80000000 + $urandom_range(0, 3);
      2: return $urandom();
      default: return $signed($urandom_range(0, 32'h00400000)) - 32'sh00200000;
    endcase
  endfunction

  function automatic idw_pkg::in_item_t make_req(logic [1:0] kind);
    idw_pkg::in_item_t r;
    r.req_type = kind;
    r.src_x = rand_coord();
    r.src_y = rand_coord();
    r.dst_x = rand_coord();
    r.dst_y = rand_coord();
    r.guess_x = rand_coord();
    r.guess_y = rand_coord();
    return r;
  endfunction

  always @(posedge clk) begin
    accepted_now = rst_n && start && !busy;
    if (accepted_now) begin
      predict_result(in_req);
      n_accepted++;
    end
  end

  // Driver.
  always @(negedge clk) begin
    if (rst_n) begin
      if (accepted_now || !start) begin
        if (gap_left > 0) begin
          gap_left--;
          start <= 1'b0;
        end else if (hold_until_drained && expected_results.size() != 0) begin
          start <= 1'b0;
        end else if (pending_reqs.size() != 0) begin
          hold_until_drained = 1'b0;
          in_req <= pending_reqs.pop_front();
          start <= 1'b1;
          gap_left = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 60) :
                     ($urandom_range(0, 1) ? 0 : $urandom_range(0, 3));
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // Monitor.
  always @(posedge clk) begin
    idw_pkg::out_item_t e;
    if (rst_n && out_valid) begin
      n_results++;
      if (expected_results.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, actual %h", $time, out_res);
      end else begin
        e = expected_results.pop_front();
        if (out_res.out_x !== e.out_x)
          $display("%0t: out_x expected %h actual %h", $time, e.out_x, out_res.out_x);
        if (out_res.out_y !== e.out_y)
          $display("%0t: out_y expected %h actual %h", $time, e.out_y, out_res.out_y);
        if (out_res.status !== e.status)
          $display("%0t: status expected %0d actual %0d", $time, e.status, out_res.status);
        if (out_res !== e) errors++;
      end
    end
  end

  initial begin
    idw_pkg::in_item_t r;
    int n;
    // Directed: empty maps, inserts at the extremes, exact hit, full table, clear.
    r = make_req(idw_pkg::REQ_FWD);
    queue_req(r);
    r = make_req(idw_pkg::REQ_BWD);
    queue_req(r);
    r = '0;
    r.req_type = idw_pkg::REQ_INSERT;
    r.src_x = 32'sh7fffffff;
    r.src_y = 32'sh80000000;
    r.dst_x = 32'sh80000000;
    r.dst_y = 32'sh7fffffff;
    queue_req(r);
    r.req_type = idw_pkg::REQ_FWD;
    queue_req(r);
    r = '0;
    r.req_type = idw_pkg::REQ_INSERT;
    r.src_x = 32'sh00010000;
    r.dst_x = 32'sh00030000;
    r.dst_y = 32'shffff0000;
    queue_req(r);
    r.req_type = idw_pkg::REQ_FWD;
    queue_req(r);
    r.src_x = 0;
    queue_req(r);
    r.req_type = idw_pkg::REQ_BWD;
    r.guess_x = 32'sh00008000;
    r.guess_y = 32'sh00001000;
    queue_req(r);
    r.guess_x = 32'sh7fffffff;
    r.guess_y = 32'sh80000000;
    queue_req(r);
    r = '1;
    r.req_type = idw_pkg::REQ_CLEAR;
    queue_req(r);
    for (int i = 0; i < idw_pkg::MAX_POINTS + 1; i++) begin
      r = make_req(idw_pkg::REQ_INSERT);
      r.src_x = $signed(i << 18);
      r.src_y = $signed(i * 32'h00013000);
      queue_req(r);
    end
    queue_req(make_req(idw_pkg::REQ_FWD));
    queue_req(make_req(idw_pkg::REQ_BWD));
    queue_req(make_req(idw_pkg::REQ_CLEAR));
    n = pending_reqs.size();
    // Random: sessions of a small table followed by maps; rarely a full table.
    while (n < 1700) begin
      int pts;
      pts = ($urandom_range(0, 19) == 0) ?
            $urandom_range(idw_pkg::MAX_POINTS - 2, idw_pkg::MAX_POINTS + 2) :
            $urandom_range(0, 6);
      queue_req(make_req(idw_pkg::REQ_CLEAR));
      for (int i = 0; i < pts; i++) queue_req(make_req(idw_pkg::REQ_INSERT));
      for (int i = $urandom_range(1, 8); i > 0; i--) begin
        r = make_req($urandom_range(0, 3) == 0 ? idw_pkg::REQ_BWD : idw_pkg::REQ_FWD);
        if (pts > 0 && $urandom_range(0, 4) == 0) r.src_x = pending_reqs[$ - 1].src_x;
        queue_req(r);
      end
      if ($urandom_range(0, 9) == 0) queue_req(make_req(2'($urandom_range(0, 3))));
      n = pending_reqs.size();
    end
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    wait (pending_reqs.size() < 800);
    hold_until_drained = 1'b1;
    wait (pending_reqs.size() == 0 && !start);
    wait (expected_results.size() == 0);
    repeat (50) @(posedge clk);
    $display("Covered %0d requests and %0d results: clears, inserts to a full table,",
             n_accepted, n_results);
    $display("forward and backward maps on empty, small and full tables.");
    if (errors == 0 && expected_results.size() == 0) begin
      $display("tb_idw_displacement_morph_core: clean");
    end else begin
      $display("tb_idw_displacement_morph_core: errors");
    end
    $finish;
  end

  initial begin
    #2000ms;
    $display("tb_idw_displacement_morph_core: errors");
    $finish;
  end

endmodule
